// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, constants and helpers for the software timer table unit.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int MAX_TIMERS = 16;
   localparam int ID_WIDTH   = 16;
   localparam int IDX_W      = $clog2(MAX_TIMERS);
   localparam int CNT_W      = IDX_W + 1;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_TIMERS);

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_KILL  = 2'd1,
      OP_QUERY = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RK_SET   = 3'd0,
      RK_KILL  = 3'd1,
      RK_QUERY = 3'd2,
      RK_FIRED = 3'd3,
      RK_TICK  = 3'd4
   } rkind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic [31:0]         deadline;
      logic [30:0]         period;
      logic                periodic;
      logic                epoch;
   } entry_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_end;
      logic out_free;
   } status_type;

   // epoch in the top bit, deadline below
   function automatic logic [32:0] arm_calc(input logic [31:0] tick,
                                            input logic [31:0] period);
      logic [32:0] sum;
      begin
         sum = {1'b0, tick} + {1'b0, period};
         arm_calc = sum;
      end
   endfunction

endpackage

// ===== hdl/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: takes a request, walks the table, then issues the final word.
// ----------------------------------------------------------------------------
module stt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  stt_pkg::status_type status,
   output stt_pkg::cmd_type    cmd
);

   stt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stt_pkg::ST_IDLE: begin
            if (req_valid) state_in = stt_pkg::ST_WALK;
         end
         stt_pkg::ST_WALK: begin
            if (status.walk_end) state_in = stt_pkg::ST_FINISH;
         end
         stt_pkg::ST_FINISH: begin
            if (status.out_free) state_in = stt_pkg::ST_IDLE;
         end
         default: state_in = stt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         stt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         stt_pkg::ST_WALK: begin
            cmd.step = !status.walk_end && status.out_free;
         end
         stt_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== hdl/stt_dp.sv =====
// ----------------------------------------------------------------------------
// stt_dp
// Datapath: timer entries, tick counter, walk pointers and result register.
// ----------------------------------------------------------------------------
module stt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  stt_pkg::cmd_type              cmd,
   output stt_pkg::status_type           status,
   input  logic [1:0]                    req_kind,
   input  logic [stt_pkg::ID_WIDTH-1:0]  req_timer_id,
   input  logic signed [31:0]            req_delay,
   input  logic [31:0]                   req_tick_step,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_result_kind,
   output logic [stt_pkg::ID_WIDTH-1:0]  rsp_event_id,
   output logic                          rsp_found,
   output logic                          rsp_table_full,
   output logic [31:0]                   rsp_ticks_now,
   output logic                          rsp_last
);

   stt_pkg::entry_type entries_ff [stt_pkg::MAX_TIMERS];

   logic [31:0]                  tick_ff, tick_in;
   logic [stt_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [stt_pkg::CNT_W-1:0]    rd_ff, rd_in;
   logic [stt_pkg::CNT_W-1:0]    wr_ff, wr_in;
   stt_pkg::op_type              op_ff, op_in;
   logic [stt_pkg::ID_WIDTH-1:0] id_ff, id_in;
   logic [31:0]                  period_ff, period_in;
   logic                         periodic_ff, periodic_in;
   logic                         wrap_ff, wrap_in;
   logic                         found_ff, found_in;

   logic                         ov_ff, ov_in;
   stt_pkg::rkind_type           ok_ff, ok_in;
   logic [stt_pkg::ID_WIDTH-1:0] oid_ff, oid_in;
   logic                         ofound_ff, ofound_in;
   logic                         ofull_ff, ofull_in;
   logic [31:0]                  oticks_ff, oticks_in;
   logic                         olast_ff, olast_in;

   logic                         we;
   logic [stt_pkg::IDX_W-1:0]    waddr;
   stt_pkg::entry_type           wdata;

   stt_pkg::entry_type           cur, nxt, setent;
   logic                         match, fire, drop;
   logic [32:0]                  armv, sarm, tsum;
   logic [31:0]                  neg;
   logic                         out_free;

   assign out_free = !ov_ff || !rsp_stall;
   assign status   = '{walk_end: (rd_ff == count_ff), out_free: out_free};

   assign cur   = entries_ff[rd_ff[stt_pkg::IDX_W-1:0]];
   assign match = (cur.id == id_ff);
   assign armv  = stt_pkg::arm_calc(tick_ff, {1'b0, cur.period});
   assign sarm  = stt_pkg::arm_calc(tick_ff, period_ff);
   assign tsum  = {1'b0, tick_ff} + {1'b0, req_tick_step};
   assign neg   = 32'd0 - req_delay;

   always_comb begin
      setent          = '0;
      setent.id       = id_ff;
      setent.deadline = sarm[31:0];
      setent.period   = period_ff[30:0];
      setent.periodic = periodic_ff;
      setent.epoch    = sarm[32];
   end

   // tick processing of the entry under the read pointer
   always_comb begin
      nxt  = cur;
      drop = 1'b0;
      if (wrap_ff) begin
         if (!cur.epoch) drop = 1'b1;
         nxt.epoch = 1'b0;
      end
      fire = !drop && !nxt.epoch && (nxt.deadline <= tick_ff);
      if (fire) begin
         if (nxt.periodic) begin
            nxt.deadline = armv[31:0];
            nxt.epoch    = armv[32];
         end else begin
            drop = 1'b1;
         end
      end
   end

   always_comb begin
      tick_in     = tick_ff;
      count_in    = count_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      period_in   = period_ff;
      periodic_in = periodic_ff;
      wrap_in     = wrap_ff;
      found_in    = found_ff;
      ov_in       = ov_ff && rsp_stall;
      ok_in       = ok_ff;
      oid_in      = oid_ff;
      ofound_in   = ofound_ff;
      ofull_in    = ofull_ff;
      oticks_in   = oticks_ff;
      olast_in    = olast_ff;
      we          = 1'b0;
      waddr       = rd_ff[stt_pkg::IDX_W-1:0];
      wdata       = cur;

      if (cmd.load) begin
         op_in       = stt_pkg::op_type'(req_kind);
         id_in       = req_timer_id;
         periodic_in = req_delay[31];
         if (req_delay[31]) begin
            period_in = neg[31] ? 32'h7FFF_FFFF : neg;
         end else begin
            period_in = req_delay;
         end
         rd_in    = '0;
         wr_in    = '0;
         found_in = 1'b0;
         wrap_in  = 1'b0;
         if (stt_pkg::op_type'(req_kind) == stt_pkg::OP_TICK) begin
            tick_in = tsum[31:0];
            wrap_in = tsum[32];
         end
      end

      if (cmd.step) begin
         rd_in = rd_ff + 1'b1;
         case (op_ff)
            stt_pkg::OP_SET: begin
               if (match && !found_ff) begin
                  found_in = 1'b1;
                  we       = 1'b1;
                  wdata    = setent;
               end
            end
            stt_pkg::OP_KILL: begin
               if (match && !found_ff) begin
                  found_in = 1'b1;
               end else begin
                  we    = 1'b1;
                  waddr = wr_ff[stt_pkg::IDX_W-1:0];
                  wr_in = wr_ff + 1'b1;
               end
            end
            stt_pkg::OP_QUERY: begin
               if (match) found_in = 1'b1;
            end
            stt_pkg::OP_TICK: begin
               if (!drop) begin
                  we    = 1'b1;
                  waddr = wr_ff[stt_pkg::IDX_W-1:0];
                  wdata = nxt;
                  wr_in = wr_ff + 1'b1;
               end
               if (fire) begin
                  ov_in     = 1'b1;
                  ok_in     = stt_pkg::RK_FIRED;
                  oid_in    = cur.id;
                  ofound_in = 1'b0;
                  ofull_in  = 1'b0;
                  oticks_in = tick_ff;
                  olast_in  = 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (cmd.finish) begin
         ov_in     = 1'b1;
         oid_in    = id_ff;
         ofound_in = found_ff;
         ofull_in  = 1'b0;
         oticks_in = tick_ff;
         olast_in  = 1'b1;
         case (op_ff)
            stt_pkg::OP_SET: begin
               ok_in = stt_pkg::RK_SET;
               if (!found_ff) begin
                  if (count_ff < stt_pkg::MAX_COUNT) begin
                     we       = 1'b1;
                     waddr    = count_ff[stt_pkg::IDX_W-1:0];
                     wdata    = setent;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ofull_in = 1'b1;
                  end
               end
            end
            stt_pkg::OP_KILL: begin
               ok_in    = stt_pkg::RK_KILL;
               count_in = wr_ff;
            end
            stt_pkg::OP_QUERY: begin
               ok_in = stt_pkg::RK_QUERY;
            end
            stt_pkg::OP_TICK: begin
               ok_in     = stt_pkg::RK_TICK;
               oid_in    = '0;
               ofound_in = 1'b0;
               count_in  = wr_ff;
            end
            default: ok_in = stt_pkg::RK_TICK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) entries_ff[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         tick_ff  <= tick_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      op_ff       <= op_in;
      id_ff       <= id_in;
      period_ff   <= period_in;
      periodic_ff <= periodic_in;
      wrap_ff     <= wrap_in;
      found_ff    <= found_in;
      ok_ff       <= ok_in;
      oid_ff      <= oid_in;
      ofound_ff   <= ofound_in;
      ofull_ff    <= ofull_in;
      oticks_ff   <= oticks_in;
      olast_ff    <= olast_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_result_kind = ok_ff;
   assign rsp_event_id    = oid_ff;
   assign rsp_found       = ofound_ff;
   assign rsp_table_full  = ofull_ff;
   assign rsp_ticks_now   = oticks_ff;
   assign rsp_last        = olast_ff;

endmodule

// ===== hdl/software_timer_table_unit.sv =====
// ----------------------------------------------------------------------------
// software_timer_table_unit
// An item is taken in the idle state. Every set, kill, query and tick then
// walks the timer entries (up to 16) in list order through a single read
// port, one entry per step; the walk holds while a word waits unaccepted
// in the output register. After the end of the walk is seen, the final
// word is issued once the output register is free. A fired timer is loaded
// into the output register in the cycle its entry is visited. A new item is
// taken only once the previous one has issued its last word; the final word
// may still wait in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module software_timer_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [stt_pkg::ID_WIDTH-1:0]  req_timer_id,
   input  logic signed [31:0]            req_delay,
   input  logic [31:0]                   req_tick_step,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_result_kind,
   output logic [stt_pkg::ID_WIDTH-1:0]  rsp_event_id,
   output logic                          rsp_found,
   output logic                          rsp_table_full,
   output logic [31:0]                   rsp_ticks_now,
   output logic                          rsp_last
);

   stt_pkg::cmd_type    cmd;
   stt_pkg::status_type status;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_timer_id    (req_timer_id),
      .req_delay       (req_delay),
      .req_tick_step   (req_tick_step),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_event_id    (rsp_event_id),
      .rsp_found       (rsp_found),
      .rsp_table_full  (rsp_table_full),
      .rsp_ticks_now   (rsp_ticks_now),
      .rsp_last        (rsp_last)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == stt_pkg::RK_FIRED) |-> !rsp_last)
      else $error("fired word marked last");

   a_other_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != stt_pkg::RK_FIRED) |-> rsp_last)
      else $error("final word not marked last");

   a_full_only_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (rsp_result_kind == stt_pkg::RK_SET
                                          && !rsp_found))
      else $error("table full flag on wrong word");

endmodule
